@@ rtl/lamp_fault_monitor_assert.svh @@
// Assertion macros used by the lamp fault monitor checker (lfm_checker).
// Needs no package; the caller supplies clock, reset and expressions.
`ifndef LAMP_FAULT_MONITOR_ASSERT_SVH
`define LAMP_FAULT_MONITOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LFM_ASSERT_NOW(label, clk, rst_n, cond, expect_now) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (cond) |-> (expect_now)) else $error("lamp fault monitor check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LFM_ASSERT_NEXT(label, clk, rst_n, cond, expect_next) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (cond) |=> (expect_next)) else $error("lamp fault monitor check failed");

`endif

@@ rtl/lfm_pkg.sv @@
// Types and codes for the lamp fault monitor.
// Used by lfm_step, lamp_fault_monitor and lfm_checker; depends on nothing.
`timescale 1ns / 1ps

package lfm_pkg;

    localparam logic [1:0] MODE_SAMPLE   = 2'd0;
    localparam logic [1:0] MODE_TURN_ON  = 2'd1;
    localparam logic [1:0] MODE_TURN_OFF = 2'd2;
    localparam logic [1:0] MODE_SET_LVL  = 2'd3;

    localparam logic [1:0] HEALTH_FAULT    = 2'd0;
    localparam logic [1:0] HEALTH_NORMAL   = 2'd1;
    localparam logic [1:0] HEALTH_ABNORMAL = 2'd2;

    localparam logic [1:0] CLASS_NONE = 2'd0;
    localparam logic [1:0] CLASS_VOLT = 2'd1;
    localparam logic [1:0] CLASS_TEMP = 2'd2;
    localparam logic [1:0] CLASS_LEAK = 2'd3;

    localparam logic [2:0] CFG_TEMP_WARN = 3'd0;
    localparam logic [2:0] CFG_TEMP_CRIT = 3'd1;
    localparam logic [2:0] CFG_LEAK      = 3'd2;
    localparam logic [2:0] CFG_VOLT_LOW  = 3'd3;
    localparam logic [2:0] CFG_VOLT_HIGH = 3'd4;

    localparam logic [6:0] LEVEL_FULL  = 7'd100;
    localparam logic [6:0] LEVEL_RESET = 7'd80;

    localparam logic signed [11:0] TEMP_WARN_RESET = 12'sd500;
    localparam logic signed [11:0] TEMP_CRIT_RESET = 12'sd600;
    localparam logic [9:0]         LEAK_RESET      = 10'd300;
    localparam logic [11:0]        VOLT_LOW_RESET  = 12'd1900;
    localparam logic [11:0]        VOLT_HIGH_RESET = 12'd2500;

    typedef struct packed {
        logic [1:0]         mode;
        logic [11:0]        supply_volts;
        logic signed [11:0] lamp_temp;
        logic [9:0]         leak_current;
        logic [6:0]         level_value;
        logic               level_present;
    } t_in_req;

    typedef struct packed {
        logic [1:0] alarm_class;
        logic       lamp_on;
        logic [6:0] level_now;
        logic [1:0] health;
    } t_out_req;

    typedef struct packed {
        logic signed [11:0] temp_warn_limit;
        logic signed [11:0] temp_crit_limit;
        logic [9:0]         leak_limit;
        logic [11:0]        volt_low_limit;
        logic [11:0]        volt_high_limit;
    } t_limits;

    typedef struct packed {
        logic       light_state;
        logic [6:0] level;
        logic [1:0] health;
    } t_lamp_state;

endpackage

@@ rtl/lfm_step.sv @@
// Next-state and alarm logic for one request of the lamp fault monitor.
// Purely combinational; depends on lfm_pkg.
`timescale 1ns / 1ps

module lfm_step
    import lfm_pkg::*;
(
    input  t_in_req     i_req,
    input  t_lamp_state i_state,
    input  t_limits     i_limits,
    output t_lamp_state o_next,
    output logic [1:0]  o_alarm_class
);

    logic lvl_in_range;

    assign lvl_in_range = (i_req.level_value <= LEVEL_FULL);

    always_comb begin
        o_next        = i_state;
        o_alarm_class = CLASS_NONE;
        case (i_req.mode)
            MODE_SAMPLE: begin
                // Checks are prioritized; the first hit decides health and class.
                if ($signed(i_req.lamp_temp) > $signed(i_limits.temp_crit_limit)) begin
                    o_next.health = HEALTH_FAULT;
                    o_alarm_class = CLASS_TEMP;
                end else if ($signed(i_req.lamp_temp) >
                             $signed(i_limits.temp_warn_limit)) begin
                    o_next.health = HEALTH_ABNORMAL;
                    o_alarm_class = CLASS_TEMP;
                end else if (i_req.leak_current > i_limits.leak_limit) begin
                    o_next.light_state = 1'b0;
                    o_next.health      = HEALTH_FAULT;
                    o_alarm_class      = CLASS_LEAK;
                end else if (i_req.supply_volts > i_limits.volt_high_limit) begin
                    o_next.health = HEALTH_ABNORMAL;
                    o_alarm_class = CLASS_VOLT;
                end else if ((i_req.supply_volts < i_limits.volt_low_limit) &&
                             i_state.light_state) begin
                    o_next.health = HEALTH_ABNORMAL;
                    o_alarm_class = CLASS_VOLT;
                end else if (i_state.health == HEALTH_ABNORMAL) begin
                    o_next.health = HEALTH_NORMAL;
                end
            end
            MODE_TURN_ON: begin
                o_next.light_state = 1'b1;
                o_next.health      = HEALTH_NORMAL;
                if (!i_req.level_present) begin
                    o_next.level = LEVEL_FULL;
                end else if ((i_req.level_value != 7'd0) && lvl_in_range) begin
                    o_next.level = i_req.level_value;
                end
            end
            MODE_TURN_OFF: begin
                o_next.light_state = 1'b0;
                o_next.level       = 7'd0;
            end
            MODE_SET_LVL: begin
                if (i_req.level_present && lvl_in_range) begin
                    o_next.level       = i_req.level_value;
                    o_next.light_state = (i_req.level_value != 7'd0);
                end
            end
            default: begin
                o_next = i_state;
            end
        endcase
    end

endmodule

@@ rtl/lamp_fault_monitor.sv @@
// Top level of the lamp fault monitor: limit registers, lamp state and result register.
// Depends on lfm_pkg and lfm_step.
`timescale 1ns / 1ps

// Usage:
// Requests arrive on the input channel (i_in_valid / o_in_ready / i_in_data). Each
// one is a sample check or a lamp command and yields exactly one result on the
// output channel (o_out_valid / i_out_ready / o_out_data), in order.
// The five limits are written through the configuration channel (i_cfg_valid /
// o_cfg_ready / i_cfg_index / i_cfg_data); indexes beyond the list are dropped.
// o_cfg_ready is always high. Write limits only while no request is in flight.
// A result is valid in the cycle after its request is accepted. Throughput is
// one request per cycle while the receiver does not stall, set by the update of
// the lamp state registers on each accepted request and the one-entry result register.
// When the receiver stalls, the result holds and o_in_ready drops until the
// result is taken; a request is still accepted in the cycle the result leaves.
// Synchronous active-low reset restores the default limits, lamp on at
// brightness 80 with normal health, and empties the result register.

module lamp_fault_monitor
    import lfm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_req     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_req    o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data
);

    t_limits     r_limits;
    t_lamp_state r_state;
    t_lamp_state n_state;
    logic [1:0]  n_class;
    logic        r_out_valid;
    t_out_req    r_out_data;
    logic        in_accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    lfm_step u_step (
        .i_req        (i_in_data),
        .i_state      (r_state),
        .i_limits     (r_limits),
        .o_next       (n_state),
        .o_alarm_class(n_class)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.temp_warn_limit <= TEMP_WARN_RESET;
            r_limits.temp_crit_limit <= TEMP_CRIT_RESET;
            r_limits.leak_limit      <= LEAK_RESET;
            r_limits.volt_low_limit  <= VOLT_LOW_RESET;
            r_limits.volt_high_limit <= VOLT_HIGH_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TEMP_WARN: r_limits.temp_warn_limit <= $signed(i_cfg_data);
                CFG_TEMP_CRIT: r_limits.temp_crit_limit <= $signed(i_cfg_data);
                CFG_LEAK:      r_limits.leak_limit      <= i_cfg_data[9:0];
                CFG_VOLT_LOW:  r_limits.volt_low_limit  <= i_cfg_data;
                CFG_VOLT_HIGH: r_limits.volt_high_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.light_state <= 1'b1;
            r_state.level       <= LEVEL_RESET;
            r_state.health      <= HEALTH_NORMAL;
            r_out_valid         <= 1'b0;
        end else begin
            if (in_accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The result carries the state as it stands after its own request.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data.alarm_class <= n_class;
            r_out_data.lamp_on     <= n_state.light_state;
            r_out_data.level_now   <= n_state.level;
            r_out_data.health      <= n_state.health;
        end
    end

endmodule

@@ rtl/lfm_checker.sv @@
// Port-level checks for the lamp fault monitor, bound to the top level.
// Depends on lfm_pkg and lamp_fault_monitor_assert.svh.
`timescale 1ns / 1ps
`include "lamp_fault_monitor_assert.svh"

module lfm_checker
    import lfm_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_out_req o_out_data
);

    logic out_stall;
    logic leak_alarm;
    logic leak_shown;
    logic any_alarm;

    assign out_stall  = o_out_valid && !i_out_ready;
    assign leak_alarm = o_out_valid && (o_out_data.alarm_class == CLASS_LEAK);
    assign leak_shown = !o_out_data.lamp_on && (o_out_data.health == HEALTH_FAULT);
    assign any_alarm  = o_out_valid && (o_out_data.alarm_class != CLASS_NONE);

    // A stalled result must not change or vanish.
    `LFM_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(o_out_data))

    // Brightness never leaves the percent range.
    `LFM_ASSERT_NOW(a_level_bound, i_clk, i_rst_n, o_out_valid, o_out_data.level_now <= LEVEL_FULL)

    // A leakage alarm switches the lamp off and reports a fault.
    `LFM_ASSERT_NOW(a_leak_off, i_clk, i_rst_n, leak_alarm, leak_shown)

    // Any temperature or voltage alarm leaves health away from normal.
    `LFM_ASSERT_NOW(a_alarm_health, i_clk, i_rst_n, any_alarm, o_out_data.health != HEALTH_NORMAL)

endmodule

bind lamp_fault_monitor lfm_checker u_lfm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);

@@ tb/lfm_outcome_checker.sv @@
// Result checker for the lamp fault monitor: tracks limit writes and lamp state,
// predicts one result per accepted request and compares it with the block's output.
// Depends on lfm_pkg.
`timescale 1ns / 1ps

module lfm_outcome_checker
    import lfm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_req     i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_req    i_out_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    t_limits     limits;
    t_lamp_state lamp;
    t_out_req    result_q[$];
    t_out_req    oldest;
    int          fail_count = 0;
    int          checked = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = result_q.size();
    assign o_checked    = checked;

    task automatic report_mismatch(input string msg);
        $display("[%0t ns] MISMATCH: %s", $time, msg);
        fail_count++;
    endtask

    // Applies one request to the tracked lamp state and returns the result it yields.
    function automatic t_out_req predict_lamp(input t_in_req req);
        t_out_req res;
        res.alarm_class = CLASS_NONE;
        case (req.mode)
            MODE_SAMPLE: begin
                if ($signed(req.lamp_temp) > $signed(limits.temp_crit_limit)) begin
                    lamp.health     = HEALTH_FAULT;
                    res.alarm_class = CLASS_TEMP;
                end else if ($signed(req.lamp_temp) > $signed(limits.temp_warn_limit)) begin
                    lamp.health     = HEALTH_ABNORMAL;
                    res.alarm_class = CLASS_TEMP;
                end else if (req.leak_current > limits.leak_limit) begin
                    lamp.light_state = 1'b0;
                    lamp.health      = HEALTH_FAULT;
                    res.alarm_class  = CLASS_LEAK;
                end else if (req.supply_volts > limits.volt_high_limit) begin
                    lamp.health     = HEALTH_ABNORMAL;
                    res.alarm_class = CLASS_VOLT;
                end else if (req.supply_volts < limits.volt_low_limit && lamp.light_state) begin
                    lamp.health     = HEALTH_ABNORMAL;
                    res.alarm_class = CLASS_VOLT;
                end else if (lamp.health == HEALTH_ABNORMAL) begin
                    lamp.health = HEALTH_NORMAL;
                end
            end
            MODE_TURN_ON: begin
                lamp.light_state = 1'b1;
                if (!req.level_present) begin
                    lamp.level = LEVEL_FULL;
                end else if (req.level_value >= 7'd1 && req.level_value <= LEVEL_FULL) begin
                    lamp.level = req.level_value;
                end
                lamp.health = HEALTH_NORMAL;
            end
            MODE_TURN_OFF: begin
                lamp.light_state = 1'b0;
                lamp.level       = '0;
            end
            default: begin
                if (req.level_present && req.level_value <= LEVEL_FULL) begin
                    lamp.level       = req.level_value;
                    lamp.light_state = (req.level_value != '0);
                end
            end
        endcase
        res.lamp_on   = lamp.light_state;
        res.level_now = lamp.level;
        res.health    = lamp.health;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            limits.temp_warn_limit = TEMP_WARN_RESET;
            limits.temp_crit_limit = TEMP_CRIT_RESET;
            limits.leak_limit      = LEAK_RESET;
            limits.volt_low_limit  = VOLT_LOW_RESET;
            limits.volt_high_limit = VOLT_HIGH_RESET;
            lamp.light_state       = 1'b1;
            lamp.level             = LEVEL_RESET;
            lamp.health            = HEALTH_NORMAL;
            result_q.delete();
        end else begin
            // The result leaving now belongs to an earlier request, so pop first.
            if (i_out_valid && i_out_ready) begin
                if (result_q.size() == 0) begin
                    report_mismatch("result arrived with no request pending");
                end else begin
                    oldest = result_q.pop_front();
                    checked++;
                    if (i_out_data.alarm_class !== oldest.alarm_class)
                        report_mismatch($sformatf("alarm_class got %0d expected %0d",
                            i_out_data.alarm_class, oldest.alarm_class));
                    if (i_out_data.lamp_on !== oldest.lamp_on)
                        report_mismatch($sformatf("lamp_on got %0d expected %0d",
                            i_out_data.lamp_on, oldest.lamp_on));
                    if (i_out_data.level_now !== oldest.level_now)
                        report_mismatch($sformatf("level_now got %0d expected %0d",
                            i_out_data.level_now, oldest.level_now));
                    if (i_out_data.health !== oldest.health)
                        report_mismatch($sformatf("health got %0d expected %0d",
                            i_out_data.health, oldest.health));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TEMP_WARN: limits.temp_warn_limit = i_cfg_data;
                    CFG_TEMP_CRIT: limits.temp_crit_limit = i_cfg_data;
                    CFG_LEAK:      limits.leak_limit      = i_cfg_data[9:0];
                    CFG_VOLT_LOW:  limits.volt_low_limit  = i_cfg_data;
                    CFG_VOLT_HIGH: limits.volt_high_limit = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                result_q.push_back(predict_lamp(i_in_data));
            end
        end
    end

endmodule

@@ tb/tb_lamp_fault_monitor.sv @@
// Testbench top for the lamp fault monitor: clock, reset, request and limit stimulus.
// Depends on lfm_pkg, lamp_fault_monitor and lfm_outcome_checker.
`timescale 1ns / 1ps

module tb_lamp_fault_monitor;
    import lfm_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in_req     in_data;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_req    out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [11:0] cfg_data;

    int fail_count;
    int pending;
    int checked;

    int      send_idle = 0;
    int      recv_idle = 0;
    int      sent_reqs = 0;
    int      settings_used = 1;
    t_limits cur_lim;
    t_limits new_lim;

    lamp_fault_monitor dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    lfm_outcome_checker u_outcome_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #6 clk = ~clk;

    always @(negedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    function automatic int clamp_int(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic t_in_req make_sample(input int volts, input int temp, input int leak);
        t_in_req r;
        r.mode          = MODE_SAMPLE;
        r.supply_volts  = volts[11:0];
        r.lamp_temp     = temp[11:0];
        r.leak_current  = leak[9:0];
        r.level_value   = 7'($urandom_range(0, 127));
        r.level_present = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic t_in_req make_cmd(input logic [1:0] mode, input int lvl, input bit has_lvl);
        t_in_req r;
        r.mode          = mode;
        r.supply_volts  = 12'($urandom_range(0, 4095));
        r.lamp_temp     = 12'($urandom_range(0, 4095));
        r.leak_current  = 10'($urandom_range(0, 1023));
        r.level_value   = lvl[6:0];
        r.level_present = has_lvl;
        return r;
    endfunction

    // Mostly samples that sit below or close to the current limits, so that every
    // stage of the priority chain is reached; the rest are lamp commands.
    function automatic t_in_req random_req(input t_limits lim);
        t_in_req r;
        int      warn;
        int      crit;
        int      lo_v;
        int      hi_v;
        int      t;
        int      l;
        int      v;
        int      pick;
        int      lvl;
        warn = int'($signed(lim.temp_warn_limit));
        crit = int'($signed(lim.temp_crit_limit));
        lo_v = int'(lim.volt_low_limit);
        hi_v = int'(lim.volt_high_limit);
        if ($urandom_range(0, 99) < 60) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                t = clamp_int(((warn < crit) ? warn : crit) - $urandom_range(0, 300), -2048, 2047);
            else if (pick < 65)
                t = clamp_int(warn + $urandom_range(0, 4) - 2, -2048, 2047);
            else if (pick < 80)
                t = clamp_int(crit + $urandom_range(0, 4) - 2, -2048, 2047);
            else
                t = $urandom_range(0, 4095);
            pick = $urandom_range(0, 99);
            if (pick < 55)
                l = $urandom_range(0, lim.leak_limit);
            else if (pick < 85)
                l = clamp_int(lim.leak_limit + $urandom_range(0, 4) - 2, 0, 1023);
            else
                l = $urandom_range(0, 1023);
            pick = $urandom_range(0, 99);
            if (pick < 40)
                v = (lo_v <= hi_v) ? $urandom_range(lo_v, hi_v) : $urandom_range(0, 4095);
            else if (pick < 60)
                v = clamp_int(lo_v + $urandom_range(0, 4) - 2, 0, 4095);
            else if (pick < 80)
                v = clamp_int(hi_v + $urandom_range(0, 4) - 2, 0, 4095);
            else
                v = $urandom_range(0, 4095);
            r = make_sample(v, t, l);
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
                lvl = 0;
            else if (pick < 30)
                lvl = 1;
            else if (pick < 45)
                lvl = 100;
            else if (pick < 55)
                lvl = 101;
            else
                lvl = $urandom_range(0, 127);
            case ($urandom_range(1, 3))
                1:       r = make_cmd(MODE_TURN_ON, lvl, $urandom_range(0, 3) != 0);
                2:       r = make_cmd(MODE_TURN_OFF, lvl, 1'($urandom_range(0, 1)));
                default: r = make_cmd(MODE_SET_LVL, lvl, $urandom_range(0, 3) != 0);
            endcase
        end
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    // Valid stays high on return so back-to-back requests follow without valid dropping.
    task automatic send_req(input t_in_req r);
        while ($urandom_range(0, 99) < send_idle) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        sent_reqs++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [11:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // Limits change only with no request in flight.
    task automatic apply_limits(input t_limits lim);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (2) @(negedge clk);
        write_reg(CFG_TEMP_WARN, lim.temp_warn_limit);
        write_reg(CFG_TEMP_CRIT, lim.temp_crit_limit);
        write_reg(CFG_LEAK, {2'($urandom_range(0, 3)), lim.leak_limit});
        write_reg(CFG_VOLT_LOW, lim.volt_low_limit);
        write_reg(CFG_VOLT_HIGH, lim.volt_high_limit);
        // An index past the register list must be dropped.
        write_reg(3'(CFG_VOLT_HIGH + $urandom_range(1, 3)), 12'($urandom_range(0, 4095)));
        cfg_valid <= 1'b0;
        cur_lim = lim;
        settings_used++;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_req(random_req(cur_lim));
    endtask

    initial begin
        int w;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        cur_lim.temp_warn_limit = TEMP_WARN_RESET;
        cur_lim.temp_crit_limit = TEMP_CRIT_RESET;
        cur_lim.leak_limit      = LEAK_RESET;
        cur_lim.volt_low_limit  = VOLT_LOW_RESET;
        cur_lim.volt_high_limit = VOLT_HIGH_RESET;
        send_idle = 30;
        recv_idle = 88;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed requests against the reset limits; the lamp starts on at 80.
        send_req(make_sample(2200, 250, 0));
        send_req(make_sample(2200, 600, 0));
        send_req(make_sample(2200, 601, 0));
        send_req(make_sample(2200, 500, 300));   // equal to limits, fault must stay
        send_req(make_cmd(MODE_TURN_ON, 0, 1'b0));
        send_req(make_sample(2500, 0, 300));
        send_req(make_sample(1900, 0, 0));
        send_req(make_sample(2200, 0, 301));
        send_req(make_cmd(MODE_TURN_ON, 0, 1'b1));
        send_req(make_sample(2501, 0, 0));
        send_req(make_sample(2200, 0, 0));
        send_req(make_sample(1899, 0, 0));
        send_req(make_cmd(MODE_TURN_OFF, 55, 1'b1));
        send_req(make_sample(1899, 0, 0));       // undervoltage ignored with the lamp off
        send_req(make_cmd(MODE_SET_LVL, 50, 1'b0));
        send_req(make_cmd(MODE_SET_LVL, 101, 1'b1));
        send_req(make_cmd(MODE_SET_LVL, 0, 1'b1));
        send_req(make_cmd(MODE_SET_LVL, 100, 1'b1));
        send_req(make_cmd(MODE_TURN_ON, 127, 1'b1));
        send_req(make_cmd(MODE_TURN_ON, 1, 1'b1));
        send_req(make_sample(0, -2048, 0));
        send_req(make_sample(4095, 2047, 1023));
        send_req(make_sample(4095, -400, 1023));
        send_req(make_cmd(MODE_SET_LVL, 127, 1'b1));
        send_req(make_cmd(MODE_TURN_ON, 100, 1'b1));

        send_random(95);

        // Extremes with both pairs of limits out of order.
        send_idle = 88;
        recv_idle = 30;
        new_lim.temp_warn_limit = 12'sd1500;
        new_lim.temp_crit_limit = -12'sd400;
        new_lim.leak_limit      = 10'd0;
        new_lim.volt_low_limit  = 12'd4095;
        new_lim.volt_high_limit = 12'd0;
        apply_limits(new_lim);
        send_random(95);

        send_idle = 0;
        recv_idle = 0;
        w = $urandom_range(0, 1900) - 400;
        new_lim.temp_warn_limit = w[11:0];
        w = $urandom_range(0, 1900) - 400;
        new_lim.temp_crit_limit = w[11:0];
        new_lim.leak_limit      = 10'($urandom_range(0, 1023));
        new_lim.volt_low_limit  = 12'($urandom_range(0, 4095));
        new_lim.volt_high_limit = 12'($urandom_range(0, 4095));
        apply_limits(new_lim);
        send_random(95);

        // The opposite extremes.
        new_lim.temp_warn_limit = -12'sd400;
        new_lim.temp_crit_limit = 12'sd1500;
        new_lim.leak_limit      = 10'd1023;
        new_lim.volt_low_limit  = 12'd0;
        new_lim.volt_high_limit = 12'd4095;
        apply_limits(new_lim);
        send_random(95);

        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);

        $display("Run covered %0d requests under %0d limit settings and three pacing mixes.",
            sent_reqs, settings_used);
        $display("%0d results were compared field by field.", checked);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results still pending.", pending);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
